@@ design/button_debounce_repeat_longpress_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the button debouncer checks
// Two property forms: same-cycle implication and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_REPEAT_LONGPRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_REPEAT_LONGPRESS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BDRL_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bdrl check failed");

// antecedent implies consequent in the next cycle
`define BDRL_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bdrl check failed");

`endif

@@ design/bdrl_pkg.sv @@
// ----------------------------------------------------------------------------
// bdrl_pkg
// Types and constants shared by the button debouncer lanes, merge and top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdrl_pkg;

  localparam int TIME_W          = 32;
  localparam int REG_W           = 16;
  localparam int FIELD_W         = 4;
  localparam int CFG_IDX_W       = 8;
  localparam int DEF_NUM_BUTTONS = 4;

  // register reset values
  localparam logic [REG_W-1:0] RST_DEBOUNCE  = 16'd30;
  localparam logic [REG_W-1:0] RST_REP_INIT  = 16'd400;
  localparam logic [REG_W-1:0] RST_REP_EVERY = 16'd120;
  localparam logic [REG_W-1:0] RST_LONG      = 16'd1500;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE  = 8'd0,
    REG_REP_INIT  = 8'd1,
    REG_REP_EVERY = 8'd2,
    REG_LONG      = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [FIELD_W-1:0] raw_levels;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pressed_events;
    logic [FIELD_W-1:0] long_events;
    logic [FIELD_W-1:0] down_levels;
  } out_word_t;

  typedef struct packed {
    logic [REG_W-1:0] debounce_ms;
    logic [REG_W-1:0] repeat_initial_ms;
    logic [REG_W-1:0] repeat_every_ms;
    logic [REG_W-1:0] long_ms;
  } cfg_t;

  // per-button findings handed from a lane to the merge stage
  typedef struct packed {
    logic press_ev;
    logic long_ev;
    logic down;
  } lane_res_t;

endpackage

`default_nettype wire

@@ design/bdrl_lane.sv @@
// ----------------------------------------------------------------------------
// bdrl_lane
// One button: debounce lockout, press/release tracking, and either
// auto-repeat (ordinary buttons) or a one-shot long press (last button).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdrl_lane #(
  parameter bit IS_LAST = 1'b0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [bdrl_pkg::TIME_W-1:0]   now_ms,
  input  wire logic                          lvl,
  input  wire bdrl_pkg::cfg_t                cfg,
  output bdrl_pkg::lane_res_t                res
);
  import bdrl_pkg::*;

  logic              stable;
  logic [TIME_W-1:0] last_chg;
  logic [TIME_W-1:0] since_chg;
  logic              chg;
  logic              press_acc;
  logic              rel_acc;
  logic              stable_next;

  // debounce: level differs and lockout has expired
  assign since_chg   = now_ms - last_chg;
  assign chg         = (lvl != stable) &&
                       (since_chg > {{(TIME_W-REG_W){1'b0}}, cfg.debounce_ms});
  assign press_acc   = chg && stable;
  assign rel_acc     = chg && !stable;
  assign stable_next = chg ? lvl : stable;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable   <= 1'b1;
      last_chg <= '0;
    end else if (step && chg) begin
      stable   <= lvl;
      last_chg <= now_ms;
    end
  end

  generate
    if (IS_LAST) begin : g_long
      logic [TIME_W-1:0] down_since;
      logic              long_done;
      logic [TIME_W-1:0] held;
      logic              long_hit;

      // on the press tick the hold time is zero, so only long_ms of zero fires
      assign held     = now_ms - down_since;
      assign long_hit = !stable_next && (press_acc ?
                          ((now_ms != '0) && (cfg.long_ms == '0)) :
                          (!long_done && (down_since != '0) &&
                           (held >= {{(TIME_W-REG_W){1'b0}}, cfg.long_ms})));

      always_ff @(posedge clk) begin
        if (rst) begin
          down_since <= '0;
          long_done  <= 1'b0;
        end else if (step) begin
          if (press_acc) begin
            down_since <= now_ms;
          end else if (rel_acc) begin
            down_since <= '0;
          end
          if (long_hit) begin
            long_done <= 1'b1;
          end else if (press_acc) begin
            long_done <= 1'b0;
          end
        end
      end

      assign res.press_ev = press_acc && !long_hit;
      assign res.long_ev  = long_hit;
    end else begin : g_repeat
      logic [TIME_W-1:0] next_rep;
      logic [TIME_W-1:0] late;
      logic              due;
      logic [TIME_W-1:0] rep_sum;

      // repeat due when now - next_rep is non-negative (signed view);
      // on the press tick next_rep would be now + initial delay
      assign late    = now_ms - next_rep;
      assign due     = !stable_next && (press_acc ?
                         ((cfg.repeat_initial_ms == '0) && (now_ms != '0)) :
                         ((next_rep != '0) && !late[TIME_W-1]));
      assign rep_sum = now_ms + {{(TIME_W-REG_W){1'b0}},
                         (due ? cfg.repeat_every_ms : cfg.repeat_initial_ms)};

      always_ff @(posedge clk) begin
        if (rst) begin
          next_rep <= '0;
        end else if (step) begin
          if (due || press_acc) begin
            next_rep <= rep_sum;
          end else if (rel_acc) begin
            next_rep <= '0;
          end
        end
      end

      assign res.press_ev = press_acc || due;
      assign res.long_ev  = 1'b0;
    end
  endgenerate

  assign res.down = !stable_next;

endmodule

`default_nettype wire

@@ design/bdrl_merge.sv @@
// ----------------------------------------------------------------------------
// bdrl_merge
// Gathers the lane findings into one result word and holds it in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdrl_merge #(
  parameter int NUM_BUTTONS = bdrl_pkg::DEF_NUM_BUTTONS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   step,
  input  wire bdrl_pkg::lane_res_t [NUM_BUTTONS-1:0]  lane_res,
  output logic                                        take,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output bdrl_pkg::out_word_t                         out_data
);
  import bdrl_pkg::*;

  out_word_t word_next;

  // output register may load when empty or being drained this cycle
  assign take = !out_valid || out_ready;

  // buttons beyond the field width are dropped; missing buttons read zero
  genvar i;
  generate
    for (i = 0; i < FIELD_W; i++) begin : g_bit
      if (i < NUM_BUTTONS) begin : g_on
        assign word_next.pressed_events[i] = lane_res[i].press_ev;
        assign word_next.long_events[i]    = lane_res[i].long_ev;
        assign word_next.down_levels[i]    = lane_res[i].down;
      end else begin : g_off
        assign word_next.pressed_events[i] = 1'b0;
        assign word_next.long_events[i]    = 1'b0;
        assign word_next.down_levels[i]    = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= word_next;
    end
  end

endmodule

`default_nettype wire

@@ design/button_debounce_repeat_longpress.sv @@
// ----------------------------------------------------------------------------
// button_debounce_repeat_longpress
// Debouncer for NUM_BUTTONS active-low buttons with auto-repeat and a long
// press on the last button.
//
// Input channel (in_valid/in_ready/in_data): one word per update tick with
// the current ms time and the raw button levels. Output channel
// (out_valid/out_ready/out_data): exactly one result word per input word,
// with press/repeat events, long-press events and debounced levels.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// writes to index 0..3 set debounce, initial repeat delay, repeat interval
// and long-press time. Other indexes are ignored.
// Result: registered; it appears in the cycle after the input word is accepted.
// Throughput: one word per cycle while out_ready is high; every button has
// its own lane, so the tick rate is bounded only by the single output register.
// Reset: all buttons released, all times cleared, registers to defaults.
// Stall: while a result waits and out_ready is low, in_ready is low; the
// next word is taken in the same cycle the waiting result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_repeat_longpress #(
  parameter int NUM_BUTTONS = bdrl_pkg::DEF_NUM_BUTTONS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bdrl_pkg::in_word_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bdrl_pkg::out_word_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bdrl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bdrl_pkg::REG_W-1:0]        cfg_data
);
  import bdrl_pkg::*;

  cfg_t                        cfg;
  logic                        step;
  logic                        take;
  lane_res_t [NUM_BUTTONS-1:0] lane_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = take;
  assign step      = in_valid && take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms       <= RST_DEBOUNCE;
      cfg.repeat_initial_ms <= RST_REP_INIT;
      cfg.repeat_every_ms   <= RST_REP_EVERY;
      cfg.long_ms           <= RST_LONG;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  cfg.debounce_ms       <= cfg_data;
        REG_REP_INIT:  cfg.repeat_initial_ms <= cfg_data;
        REG_REP_EVERY: cfg.repeat_every_ms   <= cfg_data;
        REG_LONG:      cfg.long_ms           <= cfg_data;
        default:       ;
      endcase
    end
  end

  // one lane per button; buttons past the field read as pressed
  genvar b;
  generate
    for (b = 0; b < NUM_BUTTONS; b++) begin : g_lane
      logic lvl;
      if (b < FIELD_W) begin : g_lvl
        assign lvl = in_data.raw_levels[b];
      end else begin : g_lvl0
        assign lvl = 1'b0;
      end

      bdrl_lane #(
        .IS_LAST (b == NUM_BUTTONS - 1)
      ) u_lane (
        .clk    (clk),
        .rst    (rst),
        .step   (step),
        .now_ms (in_data.now_ms),
        .lvl    (lvl),
        .cfg    (cfg),
        .res    (lane_res[b])
      );
    end
  endgenerate

  bdrl_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .lane_res  (lane_res),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ design/bdrl_checker.sv @@
// ----------------------------------------------------------------------------
// bdrl_checker
// Port-level checks on the debouncer result words, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "button_debounce_repeat_longpress_assert.svh"

module bdrl_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire bdrl_pkg::out_word_t out_data
);
  import bdrl_pkg::*;

  // any event requires the button to be down
  `BDRL_ASSERT_IMP(a_event_down, clk, rst, out_valid, (((out_data.pressed_events | out_data.long_events) & ~out_data.down_levels) == '0))

  // a long press withdraws the press event of that tick
  `BDRL_ASSERT_IMP(a_event_excl, clk, rst, out_valid, ((out_data.pressed_events & out_data.long_events) == '0))

  // a held result blocks the next input word
  `BDRL_ASSERT_IMP(a_stall_blocks, clk, rst, (out_valid && !out_ready), !in_ready)

  // a held result word stays put
  `BDRL_ASSERT_NXT(a_out_hold, clk, rst, (out_valid && !out_ready), (out_valid && $stable(out_data)))

endmodule

bind button_debounce_repeat_longpress bdrl_checker u_bdrl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
